/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Clocked assertion that is also checked around the reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

/* rtl/cpe_pkg.sv */
// Types, constants and code tables of the packed character encoder.
`timescale 1ns / 1ps

package cpe_pkg;

	// Encoding modes held in the mode register.
	typedef enum logic [1:0] {
		MODE_NIB    = 2'd0,
		MODE_SIX    = 2'd1,
		MODE_RAW    = 2'd2,
		MODE_VARINT = 2'd3
	} mode_t;

	// Table entry that marks a character without a four-bit code.
	localparam logic [7:0] NIB_NONE = 8'hFF;
	localparam logic [15:0] NIB_FIRST = 16'd97;
	localparam logic [15:0] NIB_LAST = 16'd119;
	localparam int NIB_DEPTH = 23;

	// Four-bit codes for the lower-case letters a through w.
	localparam logic [7:0] NIB_TABLE [0:NIB_DEPTH-1] = '{
		8'd2, NIB_NONE, 8'd11, 8'd9, 8'd0, 8'd15, NIB_NONE, 8'd7, 8'd4,
		NIB_NONE, NIB_NONE, 8'd10, 8'd13, 8'd5, 8'd3, NIB_NONE, NIB_NONE,
		8'd8, 8'd6, 8'd1, 8'd12, NIB_NONE, 8'd14
	};

	// Varint byte fields.
	localparam logic [7:0] DATA_BITS = 8'b0111_1111;
	localparam logic [7:0] MORE_BIT = 8'b1000_0000;

	// A code lookup: hit is low when the character has no code.
	typedef struct packed {
		logic       hit;
		logic [5:0] code;
	} code_t;

	// Pending group state carried from one character to the next.
	typedef struct packed {
		logic [17:0] codes;
		logic [1:0]  count;
		logic        err;
	} grp_t;

	// Bytes produced by one character, first byte in entry 0.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            last;
		logic            bad;
	} res_t;

	// Four-bit table lookup.
	function automatic code_t nib_lookup(input logic [15:0] c);
		code_t      r;
		logic [4:0] idx;
		logic [7:0] e;
		idx = 5'(c - NIB_FIRST);
		e = NIB_NONE;
		if (c >= NIB_FIRST && c <= NIB_LAST) begin
			e = NIB_TABLE[idx];
		end
		r.hit = (e != NIB_NONE);
		r.code = r.hit ? {2'b00, e[3:0]} : 6'd0;
		return r;
	endfunction

	// Six-bit table lookup: letters by offset, punctuation by list.
	function automatic code_t six_lookup(input logic [15:0] c);
		code_t r;
		r.hit = 1'b1;
		r.code = 6'd0;
		if (c >= 16'd65 && c <= 16'd90) begin
			r.code = 6'(c - 16'd27);
		end else if (c >= 16'd97 && c <= 16'd122) begin
			r.code = 6'(c - 16'd85);
		end else begin
			case (c)
				16'd32: r.code = 6'd0;
				16'd46: r.code = 6'd1;
				16'd33: r.code = 6'd2;
				16'd63: r.code = 6'd3;
				16'd44: r.code = 6'd4;
				16'd39: r.code = 6'd5;
				16'd34: r.code = 6'd6;
				16'd59: r.code = 6'd7;
				16'd58: r.code = 6'd8;
				16'd10: r.code = 6'd9;
				16'd45: r.code = 6'd10;
				16'd95: r.code = 6'd11;
				default: r.hit = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

/* rtl/cpe_encode.sv */
// Combinational encoder: one character and the group state in, bytes and next state out.
`timescale 1ns / 1ps

module cpe_encode (
	input  cpe_pkg::mode_t mode,
	input  logic [15:0]    char_code,
	input  logic           last_char,
	input  cpe_pkg::grp_t  grp,
	output cpe_pkg::res_t  res,
	output cpe_pkg::grp_t  grp_next
);

	cpe_pkg::code_t nib;
	cpe_pkg::code_t six;
	logic [23:0]    grp_val;

	assign nib = cpe_pkg::nib_lookup(char_code);
	assign six = cpe_pkg::six_lookup(char_code);
	assign grp_val = {grp.codes, six.code};

	// Mode-dependent byte generation and group update.
	always_comb begin
		res.cnt = 2'd0;
		res.bytes = '0;
		res.last = last_char;
		grp_next = grp;
		case (mode)
			cpe_pkg::MODE_NIB: begin
				if (!nib.hit) begin
					grp_next.err = 1'b1;
				end
				if (grp.count != 2'd0) begin
					res.cnt = 2'd1;
					res.bytes[0] = {grp.codes[3:0], nib.code[3:0]};
					grp_next.codes = '0;
					grp_next.count = 2'd0;
				end else if (last_char) begin
					res.cnt = 2'd1;
					res.bytes[0] = {nib.code[3:0], 4'd0};
				end else begin
					grp_next.codes = {14'd0, nib.code[3:0]};
					grp_next.count = 2'd1;
				end
			end
			cpe_pkg::MODE_SIX: begin
				if (!six.hit) begin
					grp_next.err = 1'b1;
				end
				if (grp.count == 2'd3 || (last_char && grp.count == 2'd2)) begin
					res.cnt = 2'd3;
					res.bytes[0] = grp_val[23:16];
					res.bytes[1] = grp_val[15:8];
					res.bytes[2] = grp_val[7:0];
					grp_next.codes = '0;
					grp_next.count = 2'd0;
				end else if (last_char && grp.count == 2'd1) begin
					res.cnt = 2'd2;
					res.bytes[0] = grp_val[15:8];
					res.bytes[1] = grp_val[7:0];
				end else if (last_char) begin
					res.cnt = 2'd1;
					res.bytes[0] = {2'b00, six.code};
				end else begin
					grp_next.codes = grp_val[17:0];
					grp_next.count = grp.count + 2'd1;
				end
			end
			cpe_pkg::MODE_RAW: begin
				res.cnt = 2'd1;
				res.bytes[0] = char_code[7:0];
			end
			default: begin
				// Varint: one, two or three 7-bit groups, low group first.
				if (char_code[15:7] == 9'd0) begin
					res.cnt = 2'd1;
					res.bytes[0] = char_code[7:0];
				end else if (char_code[15:14] == 2'd0) begin
					res.cnt = 2'd2;
					res.bytes[0] = (char_code[7:0] & cpe_pkg::DATA_BITS) | cpe_pkg::MORE_BIT;
					res.bytes[1] = {1'b0, char_code[13:7]};
				end else begin
					res.cnt = 2'd3;
					res.bytes[0] = (char_code[7:0] & cpe_pkg::DATA_BITS) | cpe_pkg::MORE_BIT;
					res.bytes[1] = {1'b1, char_code[13:7]};
					res.bytes[2] = {6'd0, char_code[15:14]};
				end
			end
		endcase
		res.bad = grp_next.err;
		// The end of a string clears the whole group state.
		if (last_char) begin
			grp_next = '0;
		end
	end

endmodule

/* rtl/cpe_out_buf.sv */
// Result register that hands out the bytes of one character, one per transaction.
`timescale 1ns / 1ps

module cpe_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  cpe_pkg::res_t res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          last_byte,
	output logic          bad_char
);

	logic [1:0]      cnt_s2;
	logic [2:0][7:0] bytes_s2;
	logic            last_s2;
	logic            bad_s2;
	logic            take;

	assign out_valid = (cnt_s2 != 2'd0);
	assign take = out_valid && out_ready;
	assign free = (cnt_s2 == 2'd0) || (cnt_s2 == 2'd1 && out_ready);
	assign out_byte = bytes_s2[0];
	assign last_byte = last_s2 && (cnt_s2 == 2'd1);
	assign bad_char = bad_s2;

	// Remaining byte count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (load) begin
			cnt_s2 <= res.cnt;
		end else if (take) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	// Byte payload shifts toward entry 0 as bytes leave.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= res.bytes;
			last_s2 <= res.last;
			bad_s2 <= res.bad;
		end else if (take) begin
			bytes_s2 <= {8'd0, bytes_s2[2], bytes_s2[1]};
		end
	end

endmodule

/* rtl/charset_pack_encoder.sv */
// Top level of the packed character encoder.
`timescale 1ns / 1ps

// Takes one 16-bit character per input transaction and emits its encoded bytes,
// one per output transaction, in four-bit pack, six-bit pack, raw or varint mode.
// A character is held in an input register, encoded combinationally against the
// pending group state, and its bytes land in a result register, from which the
// first byte is offered. A character that only extends a pending group gives no
// output transaction. A character gives up to three bytes, and the output
// moves one byte per cycle while out_ready is high; characters of one byte or
// none then also flow one per cycle.
// Write encoding_mode only while no character is in flight; a write drops any
// pending codes and keeps the sticky error flag.

module charset_pack_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  encoding_mode,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] char_code,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic        bad_char
);

	cpe_pkg::mode_t mode_q;
	cpe_pkg::grp_t  grp_q;
	cpe_pkg::grp_t  grp_next;
	cpe_pkg::res_t  res;
	logic           valid_s1;
	logic [15:0]    char_s1;
	logic           last_s1;
	logic           buf_free;
	logic           fire;

	assign cfg_ready = 1'b1;
	assign fire = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || fire;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// Mode register and group state; a configuration transaction drops pending codes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cpe_pkg::MODE_NIB;
			grp_q <= '0;
		end else if (cfg_valid) begin
			mode_q <= cpe_pkg::mode_t'(encoding_mode);
			grp_q.codes <= '0;
			grp_q.count <= 2'd0;
		end else if (fire) begin
			grp_q <= grp_next;
		end
	end

	cpe_encode u_encode (
		.mode      (mode_q),
		.char_code (char_s1),
		.last_char (last_s1),
		.grp       (grp_q),
		.res       (res),
		.grp_next  (grp_next)
	);

	cpe_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res       (res),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.bad_char  (bad_char)
	);

endmodule

/* rtl/cpe_checker.sv */
// Port-level checker for the packed character encoder and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_byte,
	input logic       bad_char
);

	// A stalled output transaction keeps its valid.
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)

	// A stalled output transaction keeps its payload.
	`ASSERT_CLK(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_byte) && $stable(last_byte) && $stable(bad_char))

	// No byte is offered in the cycle that follows reset release.
	`ASSERT_CLK_ALWAYS(a_reset_empty, clk, $rose(arst_n) |-> !out_valid)

	// The mode register takes every configuration transaction at once.
	`ASSERT_CLK(a_cfg_ready, clk, arst_n, cfg_valid |-> cfg_ready)

endmodule

bind charset_pack_encoder cpe_checker u_cpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last_byte (last_byte),
	.bad_char  (bad_char)
);
